[rtl/cbqf_pkg.sv]
// Shared types and constants for the cascaded biquad filter bank.
package cbqf_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int STATE_W      = 48;
   localparam int GUARD        = 8;
   localparam int COEF_IN_W    = 32;
   localparam int ACT_W        = 4;
   localparam int OP_W         = 2;
   localparam int STAGE_IDX_W  = 3;
   localparam int SEL_W        = 3;
   localparam int NUM_COEF     = 5;
   localparam int NUM_LANES    = 3;
   localparam int DIGIT_W      = 16;
   localparam int NUM_DIGITS   = STATE_W / DIGIT_W;
   localparam int DIG_W        = $clog2(NUM_DIGITS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_COEF   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [SEL_W-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_sel_type;

   typedef struct packed {
      logic [OP_W-1:0]               op;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [STAGE_IDX_W-1:0]        stage_index;
      logic [SEL_W-1:0]              coef_select;
      logic signed [COEF_IN_W-1:0]   coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
   } rsp_type;

   // value handed from one section to the next
   typedef struct packed {
      logic                      valid;
      logic signed [STATE_W-1:0] data;
   } link_type;

   // coefficient write broadcast to all sections
   typedef struct packed {
      logic                        valid;
      logic [STAGE_IDX_W-1:0]      stage;
      logic [SEL_W-1:0]            sel;
      logic signed [COEF_IN_W-1:0] value;
   } coef_wr_type;

endpackage

[rtl/cbqf_cell.sv]
// One biquad section: coefficients, two delay states and a digit-serial multiply datapath.
module cbqf_cell #(
   parameter int COEF_BITS = 32,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cbqf_pkg::coef_wr_type coef_wr,
   input  logic                 clear,
   input  logic                 enable,
   input  cbqf_pkg::link_type   link_in,
   output cbqf_pkg::link_type   link_out,
   output logic                 busy
);
   import cbqf_pkg::*;

   localparam int CFRAC  = COEF_BITS - 3;
   localparam int PROD_W = COEF_BITS + DIGIT_W + 1;
   localparam int ACC_W  = COEF_BITS + STATE_W + 2;
   localparam int RND_W  = ACC_W - CFRAC;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_MUL_X   = 5'b00010,
      ST_ROUND_Y = 5'b00100,
      ST_MUL_Y   = 5'b01000,
      ST_UPDATE  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [DIG_W-1:0]          dig_ff, dig_in;
   logic [DIG_W-1:0]          pdig_ff, pdig_in;
   logic                      prod_vld_ff, prod_vld_in;
   logic signed [PROD_W-1:0]  prod_ff [NUM_LANES];
   logic signed [PROD_W-1:0]  prod_in [NUM_LANES];
   logic signed [ACC_W-1:0]   acc_ff [NUM_LANES];
   logic signed [ACC_W-1:0]   acc_in [NUM_LANES];
   logic signed [STATE_W-1:0] opnd_ff, opnd_in;
   logic signed [STATE_W-1:0] z1_ff, z1_in;
   logic signed [STATE_W-1:0] z2_ff, z2_in;
   logic signed [COEF_BITS-1:0] coef_ff [NUM_COEF];
   logic signed [COEF_BITS-1:0] coef_in [NUM_COEF];
   link_type                  out_ff, out_in;

   logic signed [COEF_BITS-1:0] coef_conv;
   logic signed [COEF_BITS-1:0] mcoef [NUM_LANES];
   logic signed [DIGIT_W:0]     digit;
   logic signed [ACC_W-1:0]     addend [NUM_LANES];
   logic signed [STATE_W-1:0]   y_val;

   // Q3.29 input word brought to the section's coefficient width
   if (COEF_BITS > COEF_IN_W) begin : g_widen
      assign coef_conv = {coef_wr.value, {(COEF_BITS - COEF_IN_W){1'b0}}};
   end else begin : g_wrap
      assign coef_conv = coef_wr.value[COEF_BITS-1:0];
   end

   // drop CFRAC fraction bits (half already in the accumulator), saturate to the state width
   function automatic logic signed [STATE_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] a);
      logic signed [RND_W-1:0] q;
      logic [RND_W-STATE_W:0]  top;
      q   = a[ACC_W-1:CFRAC];
      top = q[RND_W-1:STATE_W-1];
      if ((&top) || !(|top)) begin
         rnd_sat = q[STATE_W-1:0];
      end else if (q[RND_W-1]) begin
         rnd_sat = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         rnd_sat = {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

   // current digit of the operand: low digits unsigned, top digit signed
   always_comb begin
      digit = {opnd_ff[STATE_W-1], opnd_ff[STATE_W-1 -: DIGIT_W]};
      for (int i = 0; i < NUM_DIGITS - 1; i++) begin
         if (dig_ff == DIG_W'(i)) begin
            digit = {1'b0, opnd_ff[i*DIGIT_W +: DIGIT_W]};
         end
      end
   end

   always_comb begin
      mcoef[0] = coef_ff[COEF_B0];
      mcoef[1] = (state_ff == ST_MUL_Y) ? coef_ff[COEF_A1] : coef_ff[COEF_B1];
      mcoef[2] = (state_ff == ST_MUL_Y) ? coef_ff[COEF_A2] : coef_ff[COEF_B2];
      for (int i = 0; i < NUM_LANES; i++) begin
         prod_in[i] = mcoef[i] * digit;
         addend[i]  = ACC_W'(prod_ff[i]) <<< (DIGIT_W * int'(pdig_ff));
      end
   end

   assign y_val = rnd_sat(acc_ff[0]);

   always_comb begin
      state_in    = state_ff;
      dig_in      = dig_ff;
      pdig_in     = pdig_ff;
      prod_vld_in = 1'b0;
      opnd_in     = opnd_ff;
      z1_in       = z1_ff;
      z2_in       = z2_ff;
      out_in      = '{valid: 1'b0, data: out_ff.data};
      for (int i = 0; i < NUM_LANES; i++) begin
         acc_in[i] = acc_ff[i];
      end

      // products of the previous cycle land in the accumulators
      if (prod_vld_ff) begin
         if (state_ff == ST_MUL_Y) begin
            acc_in[1] = acc_ff[1] - addend[1];
            acc_in[2] = acc_ff[2] - addend[2];
         end else begin
            for (int i = 0; i < NUM_LANES; i++) begin
               acc_in[i] = acc_ff[i] + addend[i];
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (link_in.valid) begin
               if (enable) begin
                  opnd_in   = link_in.data;
                  acc_in[0] = ACC_W'($signed({z1_ff, 1'b1, {(CFRAC-1){1'b0}}}));
                  acc_in[1] = ACC_W'($signed({z2_ff, 1'b1, {(CFRAC-1){1'b0}}}));
                  acc_in[2] = ACC_W'({1'b1, {(CFRAC-1){1'b0}}});
                  dig_in    = '0;
                  state_in  = ST_MUL_X;
               end else begin
                  out_in = link_in;
               end
            end
         end
         ST_MUL_X, ST_MUL_Y: begin
            if (dig_ff != DIG_W'(NUM_DIGITS)) begin
               prod_vld_in = 1'b1;
               pdig_in     = dig_ff;
               dig_in      = dig_ff + 1'b1;
            end else if (state_ff == ST_MUL_X) begin
               state_in = ST_ROUND_Y;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_ROUND_Y: begin
            out_in   = '{valid: 1'b1, data: y_val};
            opnd_in  = y_val;
            dig_in   = '0;
            state_in = ST_MUL_Y;
         end
         ST_UPDATE: begin
            z1_in    = rnd_sat(acc_ff[1]);
            z2_in    = rnd_sat(acc_ff[2]);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clear) begin
         z1_in = '0;
         z2_in = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_COEF; i++) begin
         coef_in[i] = coef_ff[i];
      end
      if (coef_wr.valid && (int'(coef_wr.stage) == INDEX)) begin
         unique case (coef_wr.sel)
            COEF_B0: coef_in[COEF_B0] = coef_conv;
            COEF_B1: coef_in[COEF_B1] = coef_conv;
            COEF_B2: coef_in[COEF_B2] = coef_conv;
            COEF_A1: coef_in[COEF_A1] = coef_conv;
            COEF_A2: coef_in[COEF_A2] = coef_conv;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         prod_vld_ff <= 1'b0;
         out_ff      <= '0;
         z1_ff       <= '0;
         z2_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= prod_vld_in;
         out_ff      <= out_in;
         z1_ff       <= z1_in;
         z2_ff       <= z2_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      pdig_ff     <= pdig_in;
      opnd_ff     <= opnd_in;
      for (int i = 0; i < NUM_LANES; i++) begin
         prod_ff[i] <= prod_in[i];
         acc_ff[i]  <= acc_in[i];
      end
      for (int i = 0; i < NUM_COEF; i++) begin
         coef_ff[i] <= coef_in[i];
      end
   end

   assign link_out = out_ff;
   assign busy     = (state_ff != ST_IDLE) || out_ff.valid;

endmodule

[rtl/cascaded_biquad_filter_bank.sv]
// Cascaded biquad filter bank: top level with request decode, section chain and output rounding.
//
// Up to MAX_STAGES transposed direct form II sections sit in a row; a sample is widened to
// 48 bits and walks down the row, each section handing its output to the next one. An active
// section feeds three 16-bit digits of its input through its multipliers, then rounds and
// hands on its output, and then updates its delay states, overlapping the next section; an
// unused section forwards the value through its output register. A sample holds the block
// until no section is busy and its result has left the skid slot for the output register,
// so no new request is taken while a sample is in flight or a result waits in the skid slot.
// Coefficient writes, delay clears and unused op codes give no result. A finished result sits
// in the output register while the next transaction enters.
module cascaded_biquad_filter_bank #(
   parameter int MAX_STAGES = 8,
   parameter int COEF_BITS  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cbqf_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cbqf_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cbqf_pkg::ACT_W-1:0] csr_data
);
   import cbqf_pkg::*;

   localparam int CMP_W = $clog2(MAX_STAGES + 1) + ACT_W;
   localparam int OUT_W = STATE_W + 1 - GUARD;

   logic [ACT_W-1:0] active_ff, active_in;
   link_type         start_ff, start_in;
   rsp_type          pend_ff, pend_in;
   logic             pend_vld_ff, pend_vld_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic             req_accept;
   logic             clear;
   coef_wr_type      coef_wr;
   link_type         link [MAX_STAGES+1];
   logic [MAX_STAGES-1:0] cell_busy;

   logic signed [STATE_W:0]   y_rnd;
   logic signed [OUT_W-1:0]   y_out;
   logic [OUT_W-SAMPLE_BITS:0] y_top;
   rsp_type                   result;

   assign csr_ready  = 1'b1;
   assign req_stall  = start_ff.valid || pend_vld_ff || (|cell_busy);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      start_in = '{valid: 1'b0,
                   data: STATE_W'($signed({req_data.sample_in, {GUARD{1'b0}}}))};
      clear    = 1'b0;
      coef_wr  = '{valid: 1'b0, stage: req_data.stage_index, sel: req_data.coef_select,
                   value: req_data.coef_value};
      if (req_accept) begin
         unique case (req_data.op)
            OP_SAMPLE: start_in.valid = 1'b1;
            OP_COEF:   coef_wr.valid  = 1'b1;
            OP_CLEAR:  clear          = 1'b1;
            default: ;
         endcase
      end
   end

   assign link[0] = start_ff;

   for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
      logic enable;
      assign enable = CMP_W'(k) < CMP_W'(active_ff);
      cbqf_cell #(
         .COEF_BITS (COEF_BITS),
         .INDEX     (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .coef_wr  (coef_wr),
         .clear    (clear),
         .enable   (enable),
         .link_in  (link[k]),
         .link_out (link[k+1]),
         .busy     (cell_busy[k])
      );
   end

   // back to sample precision: round half up, then saturate
   always_comb begin
      y_rnd = (STATE_W+1)'(link[MAX_STAGES].data) + (STATE_W+1)'({1'b1, {(GUARD-1){1'b0}}});
      y_out = y_rnd[STATE_W:GUARD];
      y_top = y_out[OUT_W-1:SAMPLE_BITS-1];
      if ((&y_top) || !(|y_top)) begin
         result = '{sample_out: y_out[SAMPLE_BITS-1:0], clipped: 1'b0};
      end else if (y_out[OUT_W-1]) begin
         result = '{sample_out: {1'b1, {(SAMPLE_BITS-1){1'b0}}}, clipped: 1'b1};
      end else begin
         result = '{sample_out: {1'b0, {(SAMPLE_BITS-1){1'b1}}}, clipped: 1'b1};
      end
   end

   always_comb begin
      active_in   = active_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         active_in = csr_data;
      end
      if (link[MAX_STAGES].valid) begin
         pend_in     = result;
         pend_vld_in = 1'b1;
      end
      // skid slot into the output register once it is free
      if (pend_vld_ff && (!rsp_vld_ff || !rsp_stall)) begin
         rsp_in      = pend_ff;
         rsp_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         start_ff    <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         active_ff   <= active_in;
         start_ff    <= start_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
